/* rtl/core/scrl_pkg.sv */
// Shared types and constants for the scrollback text line buffer.
// Used by scrl_line_store and scrollback_text_line_buffer_unit; depends on nothing.
package scrl_pkg;

    // Buffer geometry. LINES must be a power of two, because line indexes wrap in LINE_W bits.
    localparam int LINES    = 64;
    localparam int LINE_W   = 6;
    localparam int MAX_COLS = 128;
    localparam int COL_W    = 7;
    localparam int CELLS    = LINES * MAX_COLS;
    localparam int HWM_W    = COL_W + 1;

    // Configuration register widths and reset values.
    localparam int COLS_CFG_W = 8;
    localparam int ROWS_CFG_W = 7;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd24;
    localparam logic [COLS_CFG_W-1:0] COLS_MAX   = 8'(MAX_COLS);
    localparam logic [ROWS_CFG_W-1:0] ROWS_MAX   = 7'(LINES);

    // APB side.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Character codes.
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7F;
    localparam logic [2:0] TAB_STEP    = 3'd4;

    // Register indexes, taken from paddr[2].
    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PUT,
        S_TAB,
        S_NEWLINE,
        S_READ_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              en;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [7:0]        data;
    } t_cell_wr;

    typedef struct packed {
        logic              en;
        logic [LINE_W-1:0] line;
        logic [HWM_W-1:0]  hwm;
    } t_hwm_wr;

    typedef struct packed {
        logic              en;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } t_rd_req;

    typedef struct packed {
        logic [7:0]       data;
        logic [HWM_W-1:0] hwm;
        logic             valid;
    } t_rd_rsp;

endpackage

/* rtl/core/scrl_line_store.sv */
// Line storage: the character cell memory, the per-line high-water-mark memory
// and the per-line valid bits. Depends on scrl_pkg.
module scrl_line_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scrl_pkg::t_cell_wr i_cell_wr,
    input  scrl_pkg::t_hwm_wr  i_hwm_wr,
    input  scrl_pkg::t_rd_req  i_rd_req,
    output scrl_pkg::t_rd_rsp  o_rd_rsp
);
    import scrl_pkg::*;

    logic [7:0]       r_cells [CELLS];
    logic [HWM_W-1:0] r_hwm_mem [LINES];
    logic [LINES-1:0] r_line_valid;

    logic [7:0]       r_rd_cell;
    logic [HWM_W-1:0] r_rd_hwm;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_cell_wr.en) begin
            r_cells[{i_cell_wr.line, i_cell_wr.col}] <= i_cell_wr.data;
        end
        if (i_rd_req.en) begin
            r_rd_cell <= r_cells[{i_rd_req.line, i_rd_req.col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hwm_wr.en) begin
            r_hwm_mem[i_hwm_wr.line] <= i_hwm_wr.hwm;
        end
        if (i_rd_req.en) begin
            r_rd_hwm   <= r_hwm_mem[i_rd_req.line];
            r_rd_valid <= r_line_valid[i_rd_req.line];
        end
    end

    // A line whose bit is clear has never had its mark written and reads as blank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
        end else if (i_hwm_wr.en) begin
            r_line_valid[i_hwm_wr.line] <= 1'b1;
        end
    end

    assign o_rd_rsp.data  = r_rd_cell;
    assign o_rd_rsp.hwm   = r_rd_hwm;
    assign o_rd_rsp.valid = r_rd_valid;

endmodule

/* rtl/core/scrollback_text_line_buffer_unit.sv */
// Top level of the scrollback text line buffer: control sequencer, cursor state,
// configuration registers and output register. Depends on scrl_pkg and scrl_line_store.
//
// This block keeps a circular store of 64 text lines of 128 cells each and is fed one
// byte per write item; a read item returns one cell of the screen window, where screen
// row 0 is the buffer line screen_rows-1 lines before the cursor line. Each item yields
// exactly one result carrying the read character (0 for writes and for columns at or
// past the width) and the cursor column, cursor line and filled-line count after the
// item. Items are handled one at a time: a new item is taken only while the sequencer
// is idle and the output register is empty or is being emptied in the same cycle. A
// printable byte is dispatched, written and finished; a read is dispatched, waits for
// the cell memory and finishes; CR, backspace and ignored bytes are dispatched and
// finished; a newline or an automatic wrap adds a newline step, and a tab writes one
// space per step (up to four). The cell memory has a single write port, which stores
// one cell per cycle, and a registered read port. A newline does not sweep the
// new line: each line keeps a high-water mark of the columns written since it was last
// cleared, and cells at or beyond the mark read as spaces. Line marks have valid bits
// that reset clears at once, so the block needs no clearing pass after reset. The
// result waits in an output register; while it waits, the input is stalled. The two
// registers (screen_columns at byte address 0, screen_rows at 4) are written through
// the APB port; the user is to write them only while the block is idle, which the block
// does not enforce itself; out-of-range values are clamped to 1..128 and 1..64.
module scrollback_text_line_buffer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input item channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [7:0]                          i_char_byte,
    input  logic [scrl_pkg::LINE_W-1:0]         i_read_row,
    input  logic [scrl_pkg::COL_W-1:0]          i_read_col,
    // Result item channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_read_char,
    output logic [scrl_pkg::COL_W-1:0]          o_cursor_column,
    output logic [scrl_pkg::LINE_W-1:0]         o_cursor_line,
    output logic [scrl_pkg::LINE_W-1:0]         o_lines_filled,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scrl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [scrl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [scrl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import scrl_pkg::*;

    // Configuration registers.
    logic [COLS_CFG_W-1:0] r_cfg_cols;
    logic [ROWS_CFG_W-1:0] r_cfg_rows;
    logic                  cfg_write;
    t_reg_idx              cfg_idx;

    // Sequencer and cursor state.
    t_state              r_state, n_state;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [COL_W-1:0]    r_col, n_col;
    logic [LINE_W-1:0]   r_filled, n_filled;
    logic [HWM_W-1:0]    r_cur_hwm, n_cur_hwm;
    logic [2:0]          r_tab_left, n_tab_left;
    logic                r_put_pend, n_put_pend;
    logic [7:0]          r_read_char, n_read_char;

    // Captured item.
    logic                r_item_kind;
    logic [7:0]          r_item_char;
    logic [LINE_W-1:0]   r_item_row;
    logic [COL_W-1:0]    r_item_col;

    // Result register.
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic [COL_W-1:0]    r_out_col;
    logic [LINE_W-1:0]   r_out_line;
    logic [LINE_W-1:0]   r_out_filled;

    // Derived values.
    logic [COLS_CFG_W-1:0] width_eff;
    logic [ROWS_CFG_W-1:0] rows_eff;
    logic [LINE_W-1:0]     rows_m1;
    logic                  col_ge_w;
    logic [HWM_W-1:0]      col_inc;
    logic [HWM_W-1:0]      hwm_max;
    logic                  is_print;
    logic                  in_accept;
    logic                  out_take;

    t_cell_wr cell_wr;
    t_hwm_wr  hwm_wr;
    t_rd_req  rd_req;
    t_rd_rsp  rd_rsp;

    //------------------------------------------------------------------
    // Configuration port. Writes take effect at the access cycle.
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= COLS_RESET;
            r_cfg_rows <= ROWS_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_COLUMNS: r_cfg_cols <= pwdata[COLS_CFG_W-1:0];
                REG_ROWS:    r_cfg_rows <= pwdata[ROWS_CFG_W-1:0];
                default:     r_cfg_cols <= r_cfg_cols;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_COLUMNS: prdata = {{(APB_DATA_W-COLS_CFG_W){1'b0}}, r_cfg_cols};
            REG_ROWS:    prdata = {{(APB_DATA_W-ROWS_CFG_W){1'b0}}, r_cfg_rows};
            default:     prdata = '0;
        endcase
    end

    // Clamp the registers to their working ranges.
    always_comb begin
        if (r_cfg_cols == '0) begin
            width_eff = COLS_CFG_W'(1);
        end else if (r_cfg_cols > COLS_MAX) begin
            width_eff = COLS_MAX;
        end else begin
            width_eff = r_cfg_cols;
        end
        if (r_cfg_rows == '0) begin
            rows_eff = ROWS_CFG_W'(1);
        end else if (r_cfg_rows > ROWS_MAX) begin
            rows_eff = ROWS_MAX;
        end else begin
            rows_eff = r_cfg_rows;
        end
    end

    assign rows_m1  = LINE_W'(rows_eff - ROWS_CFG_W'(1));
    assign col_ge_w = {1'b0, r_col} >= width_eff;
    assign col_inc  = {1'b0, r_col} + HWM_W'(1);
    assign hwm_max  = (col_inc > r_cur_hwm) ? col_inc : r_cur_hwm;
    assign is_print = (r_item_char >= CH_PRINT_LO) && (r_item_char <= CH_PRINT_HI);

    //------------------------------------------------------------------
    // Handshakes. A new item is taken only from idle and only when the
    // result register is free or being emptied in the same cycle.
    //------------------------------------------------------------------
    assign out_take   = r_out_valid & ~i_out_stall;
    assign o_in_stall = ~((r_state == S_IDLE) & (~r_out_valid | ~i_out_stall));
    assign in_accept  = i_in_valid & ~o_in_stall;

    //------------------------------------------------------------------
    // Next state.
    //------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_item_kind) begin
                    n_state = S_READ_WAIT;
                end else if (is_print) begin
                    n_state = col_ge_w ? S_NEWLINE : S_PUT;
                end else if (r_item_char == CH_NL) begin
                    n_state = S_NEWLINE;
                end else if (r_item_char == CH_TAB) begin
                    n_state = col_ge_w ? S_NEWLINE : S_TAB;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_PUT: begin
                n_state = (col_inc >= width_eff) ? S_NEWLINE : S_FINISH;
            end
            S_TAB: begin
                if (col_inc >= width_eff) begin
                    n_state = S_NEWLINE;
                end else if (r_tab_left == 3'd1) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_TAB;
                end
            end
            S_NEWLINE: begin
                n_state = r_put_pend ? S_PUT : S_FINISH;
            end
            S_READ_WAIT: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Datapath and memory requests. The sequencer never reads the store
    // in a cycle in which it writes it, and a read item starts only after
    // the previous item's writes, so no forwarding is needed.
    //------------------------------------------------------------------
    always_comb begin
        n_line      = r_line;
        n_col       = r_col;
        n_filled    = r_filled;
        n_cur_hwm   = r_cur_hwm;
        n_tab_left  = r_tab_left;
        n_put_pend  = r_put_pend;
        n_read_char = r_read_char;
        cell_wr     = '0;
        hwm_wr      = '0;
        rd_req      = '0;
        case (r_state)
            S_DISPATCH: begin
                n_read_char = 8'h00;
                n_put_pend  = 1'b0;
                if (r_item_kind) begin
                    // Screen row 0 sits rows-1 lines before the cursor line.
                    rd_req.en   = 1'b1;
                    rd_req.line = r_line - rows_m1 + r_item_row;
                    rd_req.col  = r_item_col;
                end else if (is_print) begin
                    n_put_pend = col_ge_w;
                end else if (r_item_char == CH_CR) begin
                    n_col = '0;
                end else if (r_item_char == CH_BS) begin
                    if (r_col != '0) begin
                        n_col = r_col - COL_W'(1);
                    end
                end else if (r_item_char == CH_TAB) begin
                    n_tab_left = TAB_STEP - {1'b0, r_col[1:0]};
                end
            end
            S_PUT, S_TAB: begin
                cell_wr.en   = 1'b1;
                cell_wr.line = r_line;
                cell_wr.col  = r_col;
                cell_wr.data = (r_state == S_PUT) ? r_item_char : CH_SPACE;
                hwm_wr.en    = 1'b1;
                hwm_wr.line  = r_line;
                hwm_wr.hwm   = hwm_max;
                n_cur_hwm    = hwm_max;
                n_col        = col_inc[COL_W-1:0];
                n_tab_left   = r_tab_left - 3'd1;
            end
            S_NEWLINE: begin
                // The new line becomes blank by resetting its mark.
                n_line      = r_line + LINE_W'(1);
                n_col       = '0;
                n_cur_hwm   = '0;
                hwm_wr.en   = 1'b1;
                hwm_wr.line = r_line + LINE_W'(1);
                hwm_wr.hwm  = '0;
                n_put_pend  = 1'b0;
                if (r_filled < rows_m1) begin
                    n_filled = r_filled + LINE_W'(1);
                end
            end
            S_READ_WAIT: begin
                if ({1'b0, r_item_col} >= width_eff) begin
                    n_read_char = 8'h00;
                end else if (!rd_rsp.valid || ({1'b0, r_item_col} >= rd_rsp.hwm)) begin
                    n_read_char = CH_SPACE;
                end else begin
                    n_read_char = rd_rsp.data;
                end
            end
            default: begin
                n_line = r_line;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_line     <= '0;
            r_col      <= '0;
            r_filled   <= '0;
            r_cur_hwm  <= '0;
            r_tab_left <= '0;
            r_put_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_line     <= n_line;
            r_col      <= n_col;
            r_filled   <= n_filled;
            r_cur_hwm  <= n_cur_hwm;
            r_tab_left <= n_tab_left;
            r_put_pend <= n_put_pend;
        end
    end

    // Item capture and read character hold no control state.
    always_ff @(posedge i_clk) begin
        r_read_char <= n_read_char;
        if (in_accept) begin
            r_item_kind <= i_kind;
            r_item_char <= i_char_byte;
            r_item_row  <= i_read_row;
            r_item_col  <= i_read_col;
        end
    end

    //------------------------------------------------------------------
    // Result register.
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH) begin
            r_out_char   <= r_read_char;
            r_out_col    <= r_col;
            r_out_line   <= r_line;
            r_out_filled <= r_filled;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_char     = r_out_char;
    assign o_cursor_column = r_out_col;
    assign o_cursor_line   = r_out_line;
    assign o_lines_filled  = r_out_filled;

    //------------------------------------------------------------------
    // Line storage.
    //------------------------------------------------------------------
    scrl_line_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cell_wr (cell_wr),
        .i_hwm_wr  (hwm_wr),
        .i_rd_req  (rd_req),
        .o_rd_rsp  (rd_rsp)
    );

endmodule
